### design/btal_pkg.sv
// shared types and constants for the binary trie address lookup block
package btal_pkg;

  // node store size and lookup key width
  localparam int unsigned NODE_COUNT   = 65536;
  localparam int unsigned ADDRESS_BITS = 32;
  localparam int unsigned NODE_AW      = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned LVL_W        = $clog2(ADDRESS_BITS);
  localparam int unsigned NODE_W       = 64;

  // configuration register reset values
  localparam logic [31:0] SEGMENT_START_RESET = 32'd16776960;
  localparam logic [2:0]  RECORD_BYTES_RESET  = 3'd3;

  // pointer mask for three-byte records
  localparam logic [31:0] PTR_MASK_24 = 32'h00FF_FFFF;

  // apb address width and register indexes
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_SEGMENT_START = 1'b0;
  localparam logic REG_RECORD_BYTES  = 1'b1;

  // input operation codes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_BEYOND  = 2'd2
  } status_e;

  // walker states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_HOLD
  } walk_state_e;

  // input beat
  typedef struct packed {
    op_e         operation;
    logic [15:0] node_index;
    logic [31:0] left_child;
    logic [31:0] right_child;
    logic [31:0] ip_address;
  } in_item_t;

  // output beat
  typedef struct packed {
    logic [31:0] record_value;
    status_e     status;
  } out_item_t;

  // configuration register values
  typedef struct packed {
    logic [31:0] segment_start;
    logic [2:0]  record_bytes;
  } cfg_t;

  // node store access request
  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    logic [NODE_W-1:0]  wdata;
    logic [NODE_AW-1:0] raddr;
  } mem_req_t;

endpackage

### design/binary_trie_address_lookup_top.sv
// Binary trie address lookup: a node write goes to the node ram; a lookup reads one node
// per trie level from the node ram, visiting up to 32 levels, and stalls the input until
// its result beat is placed in the output register. The next item is accepted while a
// result beat waits downstream. Reset restores segment_start and record_bytes; the node
// store is not cleared and holds undefined data until written.
module binary_trie_address_lookup_top import btal_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [NODE_W-1:0] mem_rdata;

  // configuration registers
  btal_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // walk sequencer
  btal_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // node store
  btal_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### design/btal_ram.sv
// generic single-port-write, single-port-read ram with registered read
module btal_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/btal_cfg.sv
// apb configuration registers for the trie lookup
module btal_cfg import btal_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [31:0] seg_q;
  logic [2:0]  rb_q;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SEGMENT_START_RESET;
      rb_q  <= RECORD_BYTES_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SEGMENT_START: seg_q <= pwdata;
        REG_RECORD_BYTES:  rb_q  <= pwdata[2:0];
        default:           seg_q <= seg_q;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_SEGMENT_START: prdata = seg_q;
      REG_RECORD_BYTES:  prdata = {29'd0, rb_q};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.segment_start = seg_q;
  assign cfg_o.record_bytes  = rb_q;

endmodule

### design/btal_walk.sv
// trie walk sequencer: node writes, level-by-level lookup, output register
module btal_walk import btal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o,
  output mem_req_t          mem_req_o,
  input  logic [NODE_W-1:0] mem_rdata_i
);

  localparam logic [32:0] NODE_LIMIT = 33'(NODE_COUNT);

  walk_state_e             state_q, state_d;
  logic [ADDRESS_BITS-1:0] ip_q, ip_d;
  logic [LVL_W-1:0]        lvl_q, lvl_d;
  out_item_t               pend_q, pend_d;
  out_item_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic        accept;
  logic        out_free;
  logic [31:0] ptr;
  logic [31:0] ptr_mask;
  logic        done;
  out_item_t   res;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // left child in the upper half of a node, right in the lower half
  assign ptr      = ip_q[ADDRESS_BITS-1] ? mem_rdata_i[31:0] : mem_rdata_i[63:32];
  assign ptr_mask = cfg_i.record_bytes[2] ? 32'hFFFF_FFFF : PTR_MASK_24;

  // next state, node store access and result selection
  always_comb begin
    state_d     = state_q;
    ip_d        = ip_q;
    lvl_d       = lvl_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    done        = 1'b0;
    res         = '{record_value: 32'd0, status: ST_OK};

    mem_req_o.we    = accept && (in_data_i.operation == OP_WRITE)
                      && (32'(in_data_i.node_index) < NODE_COUNT);
    mem_req_o.waddr = NODE_AW'(in_data_i.node_index);
    mem_req_o.wdata = {in_data_i.left_child & ptr_mask, in_data_i.right_child & ptr_mask};
    mem_req_o.raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        // node 0 is read while idle so a lookup starts with its data ready
        if (accept && (in_data_i.operation == OP_LOOKUP)) begin
          ip_d    = in_data_i.ip_address[ADDRESS_BITS-1:0];
          lvl_d   = LVL_W'(ADDRESS_BITS - 1);
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        mem_req_o.raddr = ptr[NODE_AW-1:0];
        if (ptr >= cfg_i.segment_start) begin
          res  = '{record_value: ptr, status: ST_OK};
          done = 1'b1;
        end else if (lvl_q == '0) begin
          res  = '{record_value: 32'd0, status: ST_CORRUPT};
          done = 1'b1;
        end else if ({1'b0, ptr} >= NODE_LIMIT) begin
          res  = '{record_value: 32'd0, status: ST_BEYOND};
          done = 1'b1;
        end else begin
          lvl_d = lvl_q - LVL_W'(1);
          ip_d  = {ip_q[ADDRESS_BITS-2:0], 1'b0};
        end
        if (done) begin
          if (out_free) begin
            out_d       = res;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            pend_d  = res;
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ip_q   <= ip_d;
    lvl_q  <= lvl_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
